/* sv/nrp_pkg.sv */
// nrp_pkg: shared types, character codes and constants for the NMEA RMC position parser.
// No dependencies; every other file refers to it by scoped names.

package nrp_pkg;

  localparam int CHAR_W     = 8;
  localparam int LAT_DEG_W  = 7;
  localparam int LON_DEG_W  = 10;
  localparam int UNITS_W    = 24;
  localparam int LAT_OUT_W  = 28;
  localparam int LON_OUT_W  = 31;
  localparam int LAT_SCL_W  = 27;   // 99 * 1e6 fits
  localparam int LON_SCL_W  = 30;   // 999 * 1e6 fits
  localparam int QUOT_W     = 21;   // (9999999 + 3) / 6 fits
  localparam int PREFIX_LEN = 6;

  // floor(x / 6) == (x * DIV6_MULT) >> DIV6_SHIFT for every x below 2^25
  localparam int DIV6_SHIFT = 27;
  localparam logic [24:0] DIV6_MULT = 25'd22369622;
  localparam int DIV6_PROD_W = UNITS_W + 25;

  localparam logic [UNITS_W-1:0] MINUTE_UNITS_MAX = 24'd9999999;
  localparam logic [19:0] MICRO_PER_DEG = 20'd1000000;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A       = 8'h41;
  localparam logic [CHAR_W-1:0] CH_S       = 8'h53;
  localparam logic [CHAR_W-1:0] CH_W       = 8'h57;

  // field numbers within a line (commas seen so far)
  localparam logic [2:0] FLD_STATUS  = 3'd2;
  localparam logic [2:0] FLD_LAT     = 3'd3;
  localparam logic [2:0] FLD_LAT_HEM = 3'd4;
  localparam logic [2:0] FLD_LON     = 3'd5;
  localparam logic [2:0] FLD_LON_HEM = 3'd6;
  localparam logic [2:0] FLD_LAST    = 3'd7;

  localparam logic [2:0] LAT_DEG_DIGITS = 3'd2;
  localparam logic [2:0] LON_DEG_DIGITS = 3'd3;
  localparam logic [2:0] FRAC_MAX       = 3'd5;

  typedef struct packed {
    logic [LAT_DEG_W-1:0] lat_deg;
    logic [UNITS_W-1:0]   lat_units;
    logic                 lat_neg;
    logic [LON_DEG_W-1:0] lon_deg;
    logic [UNITS_W-1:0]   lon_units;
    logic                 lon_neg;
  } coord_snapshot_t;

  // expected tag byte at each prefix position
  function automatic logic [CHAR_W-1:0] tag_byte(input logic [2:0] idx);
    logic [CHAR_W-1:0] r;
    case (idx)
      3'd0:    r = 8'h24;  // '$'
      3'd1:    r = 8'h47;  // 'G'
      3'd2:    r = 8'h50;  // 'P'
      3'd3:    r = 8'h52;  // 'R'
      3'd4:    r = 8'h4D;  // 'M'
      3'd5:    r = 8'h43;  // 'C'
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // weight of each minute fraction digit, in 1e-5 minute
  function automatic logic [13:0] frac_weight(input logic [2:0] idx);
    logic [13:0] r;
    case (idx)
      3'd0:    r = 14'd10000;
      3'd1:    r = 14'd1000;
      3'd2:    r = 14'd100;
      3'd3:    r = 14'd10;
      3'd4:    r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/nrp_if.sv */
// Valid/ready channel interfaces for the NMEA RMC position parser.
// Depends on nrp_pkg for field widths.

interface nrp_byte_if;
  logic                          valid;
  logic                          ready;
  logic [nrp_pkg::CHAR_W-1:0]    char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface nrp_pos_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [nrp_pkg::LAT_OUT_W-1:0] latitude_micro;
  logic signed [nrp_pkg::LON_OUT_W-1:0] longitude_micro;

  modport source (output valid, output latitude_micro, output longitude_micro, input ready);
  modport sink   (input valid, input latitude_micro, input longitude_micro, output ready);
endinterface

/* sv/nrp_line_parser.sv */
// nrp_line_parser: per-line byte state (prefix, fields, status, coordinate digits).
// Depends on nrp_pkg. Flags a qualifying newline and presents the coordinate snapshot.

module nrp_line_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic [nrp_pkg::CHAR_W-1:0]     char_in,
  output logic                           emit,
  output nrp_pkg::coord_snapshot_t       snap
);

  typedef struct packed {
    logic [nrp_pkg::LON_DEG_W-1:0] deg;
    logic [nrp_pkg::UNITS_W-1:0]   units;
    logic                          stopped;
    logic                          seen_point;
    logic [2:0]                    frac;
  } acc_t;

  // one byte of a coordinate field
  function automatic acc_t coord_step(input acc_t a, input logic [7:0] c,
                                      input logic [2:0] pos, input logic [2:0] deg_len);
    acc_t        r;
    logic        digit;
    logic [3:0]  d;
    logic [27:0] wide;
    r     = a;
    digit = (c >= nrp_pkg::CH_ZERO) && (c <= nrp_pkg::CH_NINE);
    d     = 4'(c - nrp_pkg::CH_ZERO);
    wide  = 28'(a.units);
    if (!a.stopped) begin
      if (pos < deg_len) begin
        if (digit) begin
          r.deg = 10'(a.deg * 10'd10 + 10'(d));
        end else begin
          r.stopped = 1'b1;
        end
      end else if (digit) begin
        if (!a.seen_point) begin
          wide = 28'(a.units) * 28'd10 + 28'(d) * 28'd100000;
        end else if (a.frac < nrp_pkg::FRAC_MAX) begin
          wide   = 28'(a.units) + 28'(d) * 28'(nrp_pkg::frac_weight(a.frac));
          r.frac = a.frac + 3'd1;
        end
        r.units = (wide > 28'(nrp_pkg::MINUTE_UNITS_MAX)) ? nrp_pkg::MINUTE_UNITS_MAX
                                                          : wide[nrp_pkg::UNITS_W-1:0];
      end else if ((c == nrp_pkg::CH_POINT) && !a.seen_point) begin
        r.seen_point = 1'b1;
      end else begin
        r.stopped = 1'b1;
      end
    end
    return r;
  endfunction

  logic [2:0]                    prefix_count, prefix_count_next;
  logic                          prefix_failed, prefix_failed_next;
  logic [2:0]                    field_index, field_index_next;
  logic [2:0]                    field_char_count, field_char_count_next;
  logic                          status_is_active, status_is_active_next;
  logic                          field_six_present, field_six_present_next;
  logic                          number_stopped, number_stopped_next;
  logic                          seen_point, seen_point_next;
  logic [2:0]                    fraction_digits, fraction_digits_next;
  logic [nrp_pkg::LAT_DEG_W-1:0] lat_degrees, lat_degrees_next;
  logic [nrp_pkg::UNITS_W-1:0]   lat_minute_units, lat_minute_units_next;
  logic                          lat_negative, lat_negative_next;
  logic [nrp_pkg::LON_DEG_W-1:0] lon_degrees, lon_degrees_next;
  logic [nrp_pkg::UNITS_W-1:0]   lon_minute_units, lon_minute_units_next;
  logic                          lon_negative, lon_negative_next;

  logic  newline;
  acc_t  acc_in, acc_out;
  logic  lat_field, lon_field;
  logic [2:0] field_index_inc;

  assign newline = (char_in == nrp_pkg::CH_NEWLINE);
  assign emit = take && newline && (prefix_count == 3'(nrp_pkg::PREFIX_LEN)) && !prefix_failed
                && field_six_present && status_is_active;

  assign snap.lat_deg   = lat_degrees;
  assign snap.lat_units = lat_minute_units;
  assign snap.lat_neg   = lat_negative;
  assign snap.lon_deg   = lon_degrees;
  assign snap.lon_units = lon_minute_units;
  assign snap.lon_neg   = lon_negative;

  assign lat_field = (field_index == nrp_pkg::FLD_LAT);
  assign lon_field = (field_index == nrp_pkg::FLD_LON);
  assign field_index_inc = (field_index < nrp_pkg::FLD_LAST) ? field_index + 3'd1 : field_index;

  always_comb begin
    acc_in.deg        = lat_field ? 10'(lat_degrees) : lon_degrees;
    acc_in.units      = lat_field ? lat_minute_units : lon_minute_units;
    acc_in.stopped    = number_stopped;
    acc_in.seen_point = seen_point;
    acc_in.frac       = fraction_digits;
    acc_out = coord_step(acc_in, char_in, field_char_count,
                         lat_field ? nrp_pkg::LAT_DEG_DIGITS : nrp_pkg::LON_DEG_DIGITS);
  end

  always_comb begin
    prefix_count_next      = prefix_count;
    prefix_failed_next     = prefix_failed;
    field_index_next       = field_index;
    field_char_count_next  = field_char_count;
    status_is_active_next  = status_is_active;
    field_six_present_next = field_six_present;
    number_stopped_next    = number_stopped;
    seen_point_next        = seen_point;
    fraction_digits_next   = fraction_digits;
    lat_degrees_next       = lat_degrees;
    lat_minute_units_next  = lat_minute_units;
    lat_negative_next      = lat_negative;
    lon_degrees_next       = lon_degrees;
    lon_minute_units_next  = lon_minute_units;
    lon_negative_next      = lon_negative;

    if (newline) begin
      prefix_count_next      = '0;
      prefix_failed_next     = 1'b0;
      field_index_next       = '0;
      field_char_count_next  = '0;
      status_is_active_next  = 1'b0;
      field_six_present_next = 1'b0;
      number_stopped_next    = 1'b0;
      seen_point_next        = 1'b0;
      fraction_digits_next   = '0;
      lat_degrees_next       = '0;
      lat_minute_units_next  = '0;
      lat_negative_next      = 1'b0;
      lon_degrees_next       = '0;
      lon_minute_units_next  = '0;
      lon_negative_next      = 1'b0;
    end else begin
      if (prefix_count < 3'(nrp_pkg::PREFIX_LEN)) begin
        if (char_in != nrp_pkg::tag_byte(prefix_count)) begin
          prefix_failed_next = 1'b1;
        end
        prefix_count_next = prefix_count + 3'd1;
      end

      if (char_in == nrp_pkg::CH_COMMA) begin
        field_index_next = field_index_inc;
        if (field_index_inc == nrp_pkg::FLD_LAST) begin
          field_six_present_next = 1'b1;
        end
        field_char_count_next = '0;
        number_stopped_next   = 1'b0;
        seen_point_next       = 1'b0;
        fraction_digits_next  = '0;
      end else begin
        case (field_index)
          nrp_pkg::FLD_STATUS: begin
            status_is_active_next = (field_char_count == 3'd0) && (char_in == nrp_pkg::CH_A);
          end
          nrp_pkg::FLD_LAT: begin
            lat_degrees_next      = acc_out.deg[nrp_pkg::LAT_DEG_W-1:0];
            lat_minute_units_next = acc_out.units;
            number_stopped_next   = acc_out.stopped;
            seen_point_next       = acc_out.seen_point;
            fraction_digits_next  = acc_out.frac;
          end
          nrp_pkg::FLD_LAT_HEM: begin
            if (field_char_count == 3'd0) begin
              lat_negative_next = (char_in == nrp_pkg::CH_S);
            end
          end
          nrp_pkg::FLD_LON: begin
            lon_degrees_next      = acc_out.deg;
            lon_minute_units_next = acc_out.units;
            number_stopped_next   = acc_out.stopped;
            seen_point_next       = acc_out.seen_point;
            fraction_digits_next  = acc_out.frac;
          end
          nrp_pkg::FLD_LON_HEM: begin
            if (field_char_count == 3'd0) begin
              lon_negative_next = (char_in == nrp_pkg::CH_W);
            end
            field_six_present_next = 1'b1;
          end
          default: begin
          end
        endcase
        if (field_char_count < 3'd7) begin
          field_char_count_next = field_char_count + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_count      <= '0;
      prefix_failed     <= 1'b0;
      field_index       <= '0;
      field_char_count  <= '0;
      status_is_active  <= 1'b0;
      field_six_present <= 1'b0;
      number_stopped    <= 1'b0;
      seen_point        <= 1'b0;
      fraction_digits   <= '0;
      lat_degrees       <= '0;
      lat_minute_units  <= '0;
      lat_negative      <= 1'b0;
      lon_degrees       <= '0;
      lon_minute_units  <= '0;
      lon_negative      <= 1'b0;
    end else if (take) begin
      prefix_count      <= prefix_count_next;
      prefix_failed     <= prefix_failed_next;
      field_index       <= field_index_next;
      field_char_count  <= field_char_count_next;
      status_is_active  <= status_is_active_next;
      field_six_present <= field_six_present_next;
      number_stopped    <= number_stopped_next;
      seen_point        <= seen_point_next;
      fraction_digits   <= fraction_digits_next;
      lat_degrees       <= lat_degrees_next;
      lat_minute_units  <= lat_minute_units_next;
      lat_negative      <= lat_negative_next;
      lon_degrees       <= lon_degrees_next;
      lon_minute_units  <= lon_minute_units_next;
      lon_negative      <= lon_negative_next;
    end
  end

endmodule

/* sv/nrp_scaler.sv */
// nrp_scaler: converts a coordinate snapshot to signed microdegrees in two register stages.
// Depends on nrp_pkg and nrp_pos_if. Stage 1 multiplies, stage 2 adds and applies the sign.

module nrp_scaler (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  nrp_pkg::coord_snapshot_t snap,
  output logic                     ready,
  nrp_pos_if.source                pos
);

  logic out_free;

  // stage 1: degree scaling and divide-by-six via reciprocal
  logic                                s1_valid;
  logic [nrp_pkg::LAT_SCL_W-1:0]       s1_lat_scaled;
  logic [nrp_pkg::QUOT_W-1:0]          s1_lat_quot;
  logic                                s1_lat_neg;
  logic [nrp_pkg::LON_SCL_W-1:0]       s1_lon_scaled;
  logic [nrp_pkg::QUOT_W-1:0]          s1_lon_quot;
  logic                                s1_lon_neg;

  logic [nrp_pkg::DIV6_PROD_W-1:0]     lat_prod, lon_prod;
  logic [nrp_pkg::LAT_SCL_W-1:0]       lat_scaled;
  logic [nrp_pkg::LON_SCL_W-1:0]       lon_scaled;

  // stage 2: output register
  logic                                out_valid;
  logic [nrp_pkg::LAT_OUT_W-1:0]       out_lat;
  logic [nrp_pkg::LON_OUT_W-1:0]       out_lon;
  logic [nrp_pkg::LAT_OUT_W-1:0]       lat_mag;
  logic [nrp_pkg::LON_OUT_W-1:0]       lon_mag;

  assign out_free = !out_valid || pos.ready;
  assign ready    = !s1_valid || out_free;

  assign lat_prod = nrp_pkg::DIV6_PROD_W'(snap.lat_units + 24'd3)
                    * nrp_pkg::DIV6_PROD_W'(nrp_pkg::DIV6_MULT);
  assign lon_prod = nrp_pkg::DIV6_PROD_W'(snap.lon_units + 24'd3)
                    * nrp_pkg::DIV6_PROD_W'(nrp_pkg::DIV6_MULT);
  assign lat_scaled = nrp_pkg::LAT_SCL_W'(snap.lat_deg)
                      * nrp_pkg::LAT_SCL_W'(nrp_pkg::MICRO_PER_DEG);
  assign lon_scaled = nrp_pkg::LON_SCL_W'(snap.lon_deg)
                      * nrp_pkg::LON_SCL_W'(nrp_pkg::MICRO_PER_DEG);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready) begin
      s1_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ready) begin
      s1_lat_scaled <= lat_scaled;
      s1_lat_quot   <= lat_prod[nrp_pkg::DIV6_SHIFT +: nrp_pkg::QUOT_W];
      s1_lat_neg    <= snap.lat_neg;
      s1_lon_scaled <= lon_scaled;
      s1_lon_quot   <= lon_prod[nrp_pkg::DIV6_SHIFT +: nrp_pkg::QUOT_W];
      s1_lon_neg    <= snap.lon_neg;
    end
  end

  assign lat_mag = nrp_pkg::LAT_OUT_W'(s1_lat_scaled) + nrp_pkg::LAT_OUT_W'(s1_lat_quot);
  assign lon_mag = nrp_pkg::LON_OUT_W'(s1_lon_scaled) + nrp_pkg::LON_OUT_W'(s1_lon_quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_free) begin
      out_lat <= s1_lat_neg ? (~lat_mag + 1'b1) : lat_mag;
      out_lon <= s1_lon_neg ? (~lon_mag + 1'b1) : lon_mag;
    end
  end

  assign pos.valid           = out_valid;
  assign pos.latitude_micro  = $signed(out_lat);
  assign pos.longitude_micro = $signed(out_lon);

endmodule

/* sv/nmea_rmc_position_parser_unit.sv */
// nmea_rmc_position_parser_unit: top level of the NMEA RMC position parser.
// Depends on nrp_pkg, nrp_if (channels), nrp_line_parser and nrp_scaler.
//
// Usage:
//   rx  : byte channel (valid/ready, char_in). One byte of NMEA text per beat;
//         byte 10 ends a line.
//   pos : result channel (valid/ready, latitude_micro, longitude_micro), signed
//         millionths of a degree, south and west negative.
// A line yields one result beat when it starts with "$GPRMC", its status field
// is exactly "A" and field six exists; other lines yield nothing.
// Throughput: one byte per cycle, sustained, while results drain.
// Path: the result for a line passes the multiply stage, then the add/sign
//   stage into the output register, and then appears on pos.
// Reset (rst, synchronous): line state cleared, both result stages emptied.
// Stall: when pos is held off, the output register keeps its beat and the
//   multiply stage holds one more; rx.ready drops only once both are full,
//   so no result is ever lost or repeated.

module nmea_rmc_position_parser_unit (
  input  logic      clk,
  input  logic      rst,
  nrp_byte_if.sink  rx,
  nrp_pos_if.source pos
);

  logic                     take;       // byte beat accepted this cycle
  logic                     emit;       // qualifying newline accepted
  logic                     scl_ready;  // room in the result pipeline
  nrp_pkg::coord_snapshot_t snap;

  // ready is held off only by a full result pipeline, never by line state
  assign rx.ready = scl_ready;
  assign take     = rx.valid && scl_ready;

  nrp_line_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .char_in (rx.char_in),
    .emit    (emit),
    .snap    (snap)
  );

  nrp_scaler u_scaler (
    .clk   (clk),
    .rst   (rst),
    .fire  (emit),
    .snap  (snap),
    .ready (scl_ready),
    .pos   (pos)
  );

endmodule

/* sv/nrp_checker.sv */
// nrp_checker: port-level assertions for nmea_rmc_position_parser_unit, and its bind.
// Depends on nrp_pkg for widths and the newline code.

module nrp_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [nrp_pkg::CHAR_W-1:0]           char_in,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [nrp_pkg::LAT_OUT_W-1:0] latitude_micro,
  input logic signed [nrp_pkg::LON_OUT_W-1:0] longitude_micro
);

  // a fresh result follows an accepted newline beat through both result stages
  a_result_after_newline: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && (char_in == nrp_pkg::CH_NEWLINE), 2))
    else $error("result beat without a newline two cycles earlier");

  a_lat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (latitude_micro >= -28'sd100666667) && (latitude_micro <= 28'sd100666667))
    else $error("latitude out of range");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(latitude_micro) && $stable(longitude_micro))
    else $error("result changed while stalled");

endmodule

bind nmea_rmc_position_parser_unit nrp_checker u_nrp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (rx.valid),
  .in_ready        (rx.ready),
  .char_in         (rx.char_in),
  .out_valid       (pos.valid),
  .out_ready       (pos.ready),
  .latitude_micro  (pos.latitude_micro),
  .longitude_micro (pos.longitude_micro)
);

/* verif/nrp_position_checker.sv */
`timescale 1ns / 100ps
// nrp_position_checker: watches the byte and position channels of the NMEA RMC parser,
// predicts every position beat from the byte stream and compares it field by field.
// Depends on nrp_pkg for widths and character codes.

module nrp_position_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 byte_valid,
  input  logic                                 byte_ready,
  input  logic [nrp_pkg::CHAR_W-1:0]           char_in,
  input  logic                                 pos_valid,
  input  logic                                 pos_ready,
  input  logic signed [nrp_pkg::LAT_OUT_W-1:0] latitude_micro,
  input  logic signed [nrp_pkg::LON_OUT_W-1:0] longitude_micro,
  input  logic                                 run_done,
  output int                                   fix_backlog,
  output int                                   mismatches
);

  localparam logic [8*nrp_pkg::PREFIX_LEN-1:0] RMC_TAG = "$GPRMC";

  typedef struct packed {
    logic signed [nrp_pkg::LAT_OUT_W-1:0] lat;
    logic signed [nrp_pkg::LON_OUT_W-1:0] lon;
  } fix_t;

  fix_t pending_fixes [$];
  int   err_count;
  bit   leftover_checked;

  // running line state
  logic [2:0]                    tag_pos;
  bit                            tag_bad;
  logic [2:0]                    fld;
  logic [2:0]                    fld_len;
  bit                            status_a;
  bit                            hem6_seen;
  bit                            digits_halted;
  bit                            point_seen;
  logic [2:0]                    frac_taken;
  logic [nrp_pkg::LAT_DEG_W-1:0] lat_deg;
  logic [nrp_pkg::UNITS_W-1:0]   lat_units;
  bit                            lat_south;
  logic [nrp_pkg::LON_DEG_W-1:0] lon_deg;
  logic [nrp_pkg::UNITS_W-1:0]   lon_units;
  bit                            lon_west;

  task automatic flag_mismatch(input string what);
    err_count++;
    $display("%0t: position mismatch: %s", $realtime, what);
  endtask

  task automatic restart_line();
    tag_pos       = '0;
    tag_bad       = 1'b0;
    fld           = '0;
    fld_len       = '0;
    status_a      = 1'b0;
    hem6_seen     = 1'b0;
    digits_halted = 1'b0;
    point_seen    = 1'b0;
    frac_taken    = '0;
    lat_deg       = '0;
    lat_units     = '0;
    lat_south     = 1'b0;
    lon_deg       = '0;
    lon_units     = '0;
    lon_west      = 1'b0;
  endtask

  function automatic logic [nrp_pkg::UNITS_W-1:0] clamp_units(input logic [63:0] v);
    return (v > {40'd0, nrp_pkg::MINUTE_UNITS_MAX}) ? nrp_pkg::MINUTE_UNITS_MAX
                                                     : v[nrp_pkg::UNITS_W-1:0];
  endfunction

  // 1e-5 minute weight of the n-th fraction digit
  function automatic logic [63:0] frac_unit(input logic [2:0] n);
    logic [63:0] w;
    w = 64'd10000;
    repeat (n) w = w / 64'd10;
    return w;
  endfunction

  function automatic logic [63:0] to_micro_deg(input int unsigned deg,
                                               input logic [nrp_pkg::UNITS_W-1:0] units,
                                               input bit neg);
    logic [63:0] v;
    v = {32'd0, deg} * 64'd1000000 + ({40'd0, units} + 64'd3) / 64'd6;
    if (neg)
      v = 64'd0 - v;
    return v;
  endfunction

  task automatic take_coord_byte(input logic [nrp_pkg::CHAR_W-1:0] c,
                                 input logic [2:0] deg_digits,
                                 inout int unsigned deg,
                                 inout logic [nrp_pkg::UNITS_W-1:0] units);
    bit          is_digit;
    logic [63:0] d;
    is_digit = (c >= nrp_pkg::CH_ZERO) && (c <= nrp_pkg::CH_NINE);
    d = {56'd0, c - nrp_pkg::CH_ZERO};
    if (digits_halted)
      return;
    if (fld_len < deg_digits) begin
      if (is_digit)
        deg = deg * 10 + d[31:0];
      else
        digits_halted = 1'b1;
    end else if (is_digit) begin
      if (!point_seen) begin
        units = clamp_units({40'd0, units} * 64'd10 + d * 64'd100000);
      end else if (frac_taken < nrp_pkg::FRAC_MAX) begin
        units = clamp_units({40'd0, units} + d * frac_unit(frac_taken));
        frac_taken++;
      end
    end else if (c == nrp_pkg::CH_POINT && !point_seen) begin
      point_seen = 1'b1;
    end else begin
      digits_halted = 1'b1;
    end
  endtask

  task automatic parse_nmea_byte(input logic [nrp_pkg::CHAR_W-1:0] c);
    fix_t        fix;
    int unsigned deg;
    logic [63:0] v;
    if (c == nrp_pkg::CH_NEWLINE) begin
      if (tag_pos == nrp_pkg::PREFIX_LEN && !tag_bad && hem6_seen && status_a) begin
        v = to_micro_deg(lat_deg, lat_units, lat_south);
        fix.lat = v[nrp_pkg::LAT_OUT_W-1:0];
        v = to_micro_deg(lon_deg, lon_units, lon_west);
        fix.lon = v[nrp_pkg::LON_OUT_W-1:0];
        pending_fixes.insert(pending_fixes.size(), fix);
      end
      restart_line();
      return;
    end
    if (tag_pos < nrp_pkg::PREFIX_LEN) begin
      if (c != RMC_TAG[8*(nrp_pkg::PREFIX_LEN-1-tag_pos) +: 8])
        tag_bad = 1'b1;
      tag_pos++;
    end
    if (c == nrp_pkg::CH_COMMA) begin
      if (fld < nrp_pkg::FLD_LAST)
        fld++;
      if (fld == nrp_pkg::FLD_LAST)
        hem6_seen = 1'b1;
      fld_len       = '0;
      digits_halted = 1'b0;
      point_seen    = 1'b0;
      frac_taken    = '0;
      return;
    end
    case (fld)
      nrp_pkg::FLD_STATUS: status_a = (fld_len == 0) && (c == nrp_pkg::CH_A);
      nrp_pkg::FLD_LAT: begin
        deg = lat_deg;
        take_coord_byte(c, nrp_pkg::LAT_DEG_DIGITS, deg, lat_units);
        lat_deg = deg[nrp_pkg::LAT_DEG_W-1:0];
      end
      nrp_pkg::FLD_LAT_HEM: begin
        if (fld_len == 0)
          lat_south = (c == nrp_pkg::CH_S);
      end
      nrp_pkg::FLD_LON: begin
        deg = lon_deg;
        take_coord_byte(c, nrp_pkg::LON_DEG_DIGITS, deg, lon_units);
        lon_deg = deg[nrp_pkg::LON_DEG_W-1:0];
      end
      nrp_pkg::FLD_LON_HEM: begin
        if (fld_len == 0)
          lon_west = (c == nrp_pkg::CH_W);
        hem6_seen = 1'b1;
      end
      default: ;
    endcase
    if (fld_len < 3'd7)
      fld_len++;
  endtask

  always @(posedge clk) begin
    fix_t want;
    if (rst) begin
      restart_line();
      pending_fixes.delete();
    end else begin
      // predict first, so a byte and a beat on the same edge stay in order
      if (byte_valid && byte_ready)
        parse_nmea_byte(char_in);
      if (pos_valid && pos_ready) begin
        if (pending_fixes.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat lat %0d lon %0d",
                                  latitude_micro, longitude_micro));
        end else begin
          want = pending_fixes.pop_front();
          if (latitude_micro !== want.lat)
            flag_mismatch($sformatf("latitude_micro got %0d want %0d",
                                    latitude_micro, want.lat));
          if (longitude_micro !== want.lon)
            flag_mismatch($sformatf("longitude_micro got %0d want %0d",
                                    longitude_micro, want.lon));
        end
      end
      if (run_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (pending_fixes.size() != 0)
          flag_mismatch($sformatf("%0d positions never arrived", pending_fixes.size()));
      end
    end
    fix_backlog <= pending_fixes.size();
    mismatches  <= err_count;
  end

endmodule

/* verif/tb_nmea_rmc_position_parser_unit.sv */
`timescale 1ns / 100ps
// tb_nmea_rmc_position_parser_unit: drives NMEA text into the parser and drains positions.
// Depends on nrp_pkg, nrp_if, the parser RTL and nrp_position_checker.

module tb_nmea_rmc_position_parser_unit;

  localparam logic [nrp_pkg::CHAR_W-1:0] CH_CR = 8'h0D;
  localparam int RANDOM_BYTES = 1500;  // random text after the directed lines
  localparam int HOLD_CYCLES  = 240;   // long sink hold-off, fills both result stages
  localparam int DRAIN_CYCLES = 20;    // settle time once nothing is outstanding

  logic clk = 1'b0;
  logic rst;
  logic run_done;

  always #10 clk = ~clk;

  nrp_byte_if rx_ch ();
  nrp_pos_if  pos_ch ();

  nmea_rmc_position_parser_unit dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .pos (pos_ch)
  );

  int fix_backlog;
  int mismatches;

  nrp_position_checker position_check (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (rx_ch.valid),
    .byte_ready      (rx_ch.ready),
    .char_in         (rx_ch.char_in),
    .pos_valid       (pos_ch.valid),
    .pos_ready       (pos_ch.ready),
    .latitude_micro  (pos_ch.latitude_micro),
    .longitude_micro (pos_ch.longitude_micro),
    .run_done        (run_done),
    .fix_backlog     (fix_backlog),
    .mismatches      (mismatches)
  );

  // Text of the line being built, sent byte by byte.
  logic [nrp_pkg::CHAR_W-1:0] line_buf [$];
  int bytes_sent;
  bit tx_no_gaps;    // sender offers back to back while set
  bit rx_no_gaps;    // sink accepts back to back while set
  bit hold_off_req;  // stimulus asks the sink for one long hold-off

  // Directed lines: extremes, status and field-six rules, stop rules, short lines.
  string directed_text [13] = '{
    "$GPRMC,,A,99999999.9999999,S,999999999.99999,W\n",  // saturated, south/west max
    "$GPRMC,,A,9960,N,99960,E\n",                         // 60 minutes in both fields
    "$GPRMC,,A,,,,,\n",                                   // empty coords, 7th comma
    "$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n",
    "$GPRMC,,V,4807.038,N,01131.000,E\n",                 // void status
    "$GPRMC,,AA,4807.038,N,01131.000,E\n",                // status not exactly A
    "$GPRMC,,A,4807.038,N,01131.000\n",                   // no field six
    "$GPRMC,,A,4807.038,N,01131.000,\n",                  // field six empty
    "$GPRMC,,A,4x07.5,S,0.7,W\n",                         // non-digit in degrees
    "$GPRMC,,A,12.34.5,Q,01234.1234567,Q\n",              // 2nd point, long fraction
    "$GPRM\n",                                            // shorter than the tag
    "\n",
    "x$GPRMC,,A,1,N,1,E\n"                                // tag shifted by one byte
  };

  task automatic append_byte(input logic [nrp_pkg::CHAR_W-1:0] b);
    line_buf.insert(line_buf.size(), b);
  endtask

  // One byte beat; the gap before it is drawn per beat unless back to back.
  task automatic send_byte(input logic [nrp_pkg::CHAR_W-1:0] b);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.char_in <= b;
    @(posedge clk);
    while (rx_ch.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic flush_line();
    foreach (line_buf[i])
      send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      append_byte(s[i]);
  endtask

  task automatic queue_digits(input int n);
    repeat (n) append_byte(8'(nrp_pkg::CH_ZERO + $urandom_range(0, 9)));
  endtask

  // Hemisphere field: mostly a proper letter, sometimes empty, junk or two bytes.
  task automatic queue_hemisphere(input logic [nrp_pkg::CHAR_W-1:0] plus_ch,
                                  input logic [nrp_pkg::CHAR_W-1:0] minus_ch);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 1) begin
      append_byte(8'($urandom_range(33, 126)));
    end else if (pick == 2) begin
      append_byte(plus_ch);
      append_byte(minus_ch);
    end else if (pick != 0) begin
      append_byte($urandom_range(0, 1) ? minus_ch : plus_ch);
    end
  endtask

  // Coordinate field: degrees, minutes, optional fraction; a few empty,
  // saturating, short, over-long or broken by a stray byte.
  task automatic queue_coord(input int deg_digits);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      return;
    if (pick == 1) begin
      repeat (deg_digits) append_byte(nrp_pkg::CH_NINE);
      queue_text("9999999.9999999");
      return;
    end
    queue_digits(pick == 2 ? $urandom_range(0, deg_digits) : deg_digits);
    queue_digits(pick == 3 ? $urandom_range(3, 6) : 2);
    if (pick < 16) begin
      append_byte(nrp_pkg::CH_POINT);
      queue_digits($urandom_range(0, 7));
    end
    if (pick >= 17) begin
      append_byte(8'($urandom_range(33, 126)));
      queue_digits($urandom_range(0, 3));
    end
  endtask

  // A $GPRMC sentence with random content, now and then damaged.
  task automatic build_rmc_line();
    int pick;
    queue_text("$GPRMC,");
    queue_digits($urandom_range(0, 6));
    append_byte(nrp_pkg::CH_COMMA);
    pick = $urandom_range(0, 11);
    if (pick == 1)
      queue_text("V");
    else if (pick == 2)
      queue_text("AV");
    else if (pick != 0)
      append_byte(nrp_pkg::CH_A);
    append_byte(nrp_pkg::CH_COMMA);
    queue_coord(nrp_pkg::LAT_DEG_DIGITS);
    append_byte(nrp_pkg::CH_COMMA);
    queue_hemisphere("N", nrp_pkg::CH_S);
    append_byte(nrp_pkg::CH_COMMA);
    queue_coord(nrp_pkg::LON_DEG_DIGITS);
    pick = $urandom_range(0, 11);
    if (pick != 0) begin
      append_byte(nrp_pkg::CH_COMMA);
      if (pick != 1)
        queue_hemisphere("E", nrp_pkg::CH_W);
      // trailing fields push the field count past saturation
      repeat ($urandom_range(0, 3)) begin
        append_byte(nrp_pkg::CH_COMMA);
        queue_digits($urandom_range(0, 4));
      end
    end
    // damage: one byte overwritten, or the tail cut off
    if ($urandom_range(0, 14) == 0)
      line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 14) == 0) begin
      pick = $urandom_range(0, line_buf.size());
      while (line_buf.size() > pick) void'(line_buf.pop_back());
    end
    if ($urandom_range(0, 1))
      append_byte(CH_CR);
    append_byte(nrp_pkg::CH_NEWLINE);
  endtask

  // Sink side: a drawn gap before each beat, stretches with none, and the
  // long hold-off on request.
  initial begin
    int gap;
    pos_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pos_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 19) == 0)
        rx_no_gaps = !rx_no_gaps;
      gap = rx_no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        pos_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pos_ch.ready <= 1'b1;
      @(posedge clk);
      while (pos_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  // Source side and verdict.
  initial begin
    int random_start;
    int line_no;
    int pick;
    rst           <= 1'b1;
    run_done      <= 1'b0;
    rx_ch.valid   <= 1'b0;
    rx_ch.char_in <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_text[i]) begin
      queue_text(directed_text[i]);
      flush_line();
    end
    // bytes 0 and 255: one in field 1, one stopping the latitude digits
    queue_text("$GPRMC,");
    append_byte(8'h00);
    queue_text(",A,12");
    append_byte(8'hFF);
    queue_text("34,S,123,W\n");
    flush_line();

    // Random part. Lines 1-7 and 30-37 go back to back while the sink
    // holds off, so the result stages fill and rx.ready must drop.
    random_start = bytes_sent;
    line_no = 0;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      line_no++;
      if (line_no == 1 || line_no == 30)
        hold_off_req = 1'b1;
      tx_no_gaps = (line_no < 8) || (line_no >= 30 && line_no < 38) ||
                   ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        // raw noise, any byte value
        repeat ($urandom_range(0, 30)) append_byte(8'($urandom_range(0, 255)));
        append_byte(nrp_pkg::CH_NEWLINE);
      end else begin
        build_rmc_line();
      end
      flush_line();
    end

    // a complete-looking sentence with no newline must never be reported
    tx_no_gaps = 1'b0;
    queue_text("$GPRMC,,A,1234.5,N,01234.5,E");
    flush_line();
    rx_ch.valid <= 1'b0;

    @(posedge clk);
    while (fix_backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0)
      $display("tb_nmea_rmc_position_parser_unit OK");
    else
      $display("tb_nmea_rmc_position_parser_unit NOT OK");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10ms;
    $display("tb_nmea_rmc_position_parser_unit NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
sv/nrp_pkg.sv
sv/nrp_if.sv
sv/nrp_line_parser.sv
sv/nrp_scaler.sv
sv/nmea_rmc_position_parser_unit.sv
sv/nrp_checker.sv
verif/nrp_position_checker.sv
verif/tb_nmea_rmc_position_parser_unit.sv
